[rtl/scm_pkg.sv]
// Shared constants, types and round functions for the stream cipher MAC core.
`timescale 1ns / 1ps
package scm_pkg;

  localparam int RegN = 16;
  localparam int KeyPos = 13;
  localparam int MacMaxBytes = 64;
  localparam logic [31:0] InitConst = 32'h6996c53a;

  localparam logic [2:0] CMD_KEY = 3'd0;
  localparam logic [2:0] CMD_NONCE = 3'd1;
  localparam logic [2:0] CMD_ENC = 3'd2;
  localparam logic [2:0] CMD_DEC = 3'd3;
  localparam logic [2:0] CMD_FINISH = 3'd4;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_FIB = 4'd1;  // Fibonacci preset, konst init
  localparam logic [3:0] OP_RESTORE = 4'd2;  // saved copy, konst init
  localparam logic [3:0] OP_LOADW = 4'd3;  // xor masked word at key pos, step
  localparam logic [3:0] OP_LOADLEN = 4'd4;  // xor length, step, copy to crc
  localparam logic [3:0] OP_SPREAD = 4'd5;  // one step
  localparam logic [3:0] OP_LOADEND = 4'd6;  // fold crc, konst, maybe save
  localparam logic [3:0] OP_CRYPT = 4'd7;  // one data word
  localparam logic [3:0] OP_FIN0 = 4'd8;  // absorb partial, step
  localparam logic [3:0] OP_FIN1 = 4'd9;  // xor tag at key pos, fold crc
  localparam logic [3:0] OP_MACW = 4'd10;  // step, present keystream

  typedef struct packed {
    logic [3:0] op;
    logic save;
    logic enc;
  } scm_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] w, input int s);
    rotl = (w << s) | (w >> (32 - s));
  endfunction

  function automatic logic [31:0] mix_a(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (rotl(w, 5) | rotl(w, 7));
    mix_a = v ^ (rotl(v, 19) | rotl(v, 22));
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (rotl(w, 7) | rotl(w, 22));
    mix_b = v ^ (rotl(v, 5) | rotl(v, 19));
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    case (n)
      3'd0: byte_mask = 32'h0;
      3'd1: byte_mask = 32'h000000ff;
      3'd2: byte_mask = 32'h0000ffff;
      3'd3: byte_mask = 32'h00ffffff;
      default: byte_mask = 32'hffffffff;
    endcase
  endfunction

endpackage

[rtl/scm_datapath.sv]
// Cipher register, CRC register, saved copy and byte-level crypt logic.
`timescale 1ns / 1ps
module scm_datapath (
  input  logic clk,
  input  logic rst,
  input  scm_pkg::scm_cmd_t cmd,
  input  logic [31:0] word,
  input  logic [2:0] nbytes,
  output logic [31:0] res_word,
  output logic [31:0] ks_out
);

  logic [31:0] r [scm_pkg::RegN];
  logic [31:0] crc [scm_pkg::RegN];
  logic [31:0] saved [scm_pkg::RegN];
  logic [31:0] konst, ks, pmac, load_len;
  logic [5:0] bits_left;

  logic [31:0] r_next [scm_pkg::RegN];
  logic [31:0] crc_next [scm_pkg::RegN];
  logic [31:0] konst_next, ks_next, pmac_next, load_len_next;
  logic [5:0] bits_left_next;

  assign ks_out = ks;

  // one register step on a given array
  function automatic void do_step(ref logic [31:0] a [scm_pkg::RegN],
                                  input logic [31:0] k, output logic [31:0] kso);
    logic [31:0] t;
    logic [31:0] t2;
    t = scm_pkg::mix_a(a[12] ^ a[13] ^ k) ^ scm_pkg::rotl(a[0], 1);
    for (int i = 0; i < scm_pkg::RegN - 1; i++) a[i] = a[i + 1];
    a[scm_pkg::RegN - 1] = t;
    t2 = scm_pkg::mix_b(a[2] ^ a[15]);
    a[0] = a[0] ^ t2;
    kso = t2 ^ a[8] ^ a[12];
  endfunction

  function automatic void do_absorb(ref logic [31:0] a [scm_pkg::RegN],
                                    ref logic [31:0] c [scm_pkg::RegN],
                                    input logic [31:0] w);
    logic [31:0] t;
    t = c[0] ^ c[2] ^ c[15] ^ w;
    for (int i = 0; i < scm_pkg::RegN - 1; i++) c[i] = c[i + 1];
    c[scm_pkg::RegN - 1] = t;
    a[scm_pkg::KeyPos] = a[scm_pkg::KeyPos] ^ w;
  endfunction

  // Fibonacci preset value of entry n
  function automatic logic [31:0] fib_rst(input int n);
    logic [31:0] a, b, t;
    a = 32'd1;
    b = 32'd1;
    for (int i = 2; i <= 15; i++) begin
      if (i <= n) begin
        t = a + b;
        a = b;
        b = t;
      end
    end
    fib_rst = b;
  endfunction

  always_comb begin
    logic [31:0] fib [scm_pkg::RegN];
    logic [31:0] res, bi, bo, kso;
    logic [2:0] pos;
    logic [5:0] sh;
    for (int i = 0; i < scm_pkg::RegN; i++) begin
      r_next[i] = r[i];
      crc_next[i] = crc[i];
    end
    konst_next = konst;
    ks_next = ks;
    pmac_next = pmac;
    load_len_next = load_len;
    bits_left_next = bits_left;
    res = 32'h0;
    bi = 32'h0;
    bo = 32'h0;
    sh = 6'd0;
    kso = ks;
    pos = 3'd0;
    fib[0] = 32'd1;
    fib[1] = 32'd1;
    for (int i = 2; i < scm_pkg::RegN; i++) fib[i] = fib[i - 1] + fib[i - 2];
    unique case (cmd.op) inside
      scm_pkg::OP_FIB, scm_pkg::OP_RESTORE: begin
        for (int i = 0; i < scm_pkg::RegN; i++)
          r_next[i] = (cmd.op == scm_pkg::OP_FIB) ? fib[i] : saved[i];
        konst_next = scm_pkg::InitConst;
        load_len_next = 32'h0;
      end
      scm_pkg::OP_LOADW: begin
        r_next[scm_pkg::KeyPos] = r[scm_pkg::KeyPos] ^ (word & scm_pkg::byte_mask(nbytes));
        do_step(r_next, konst, kso);
        ks_next = kso;
        load_len_next = load_len + {29'h0, nbytes};
      end
      scm_pkg::OP_LOADLEN: begin
        r_next[scm_pkg::KeyPos] = r[scm_pkg::KeyPos] ^ load_len;
        do_step(r_next, konst, kso);
        ks_next = kso;
        for (int i = 0; i < scm_pkg::RegN; i++) crc_next[i] = r_next[i];
      end
      scm_pkg::OP_SPREAD, scm_pkg::OP_MACW: begin
        do_step(r_next, konst, kso);
        ks_next = kso;
      end
      scm_pkg::OP_LOADEND: begin
        for (int i = 0; i < scm_pkg::RegN; i++) r_next[i] = r[i] ^ crc[i];
        konst_next = r[0] ^ crc[0];
        bits_left_next = 6'd0;
      end
      scm_pkg::OP_FIN0: begin
        if (bits_left != 6'd0) do_absorb(r_next, crc_next, pmac);
        do_step(r_next, konst, kso);
        ks_next = kso;
      end
      scm_pkg::OP_FIN1: begin
        r_next[scm_pkg::KeyPos] = r[scm_pkg::KeyPos] ^ scm_pkg::InitConst
                                  ^ {23'h0, bits_left, 3'b000};
        bits_left_next = 6'd0;
        for (int i = 0; i < scm_pkg::RegN; i++) r_next[i] = r_next[i] ^ crc[i];
      end
      scm_pkg::OP_CRYPT: begin
        // drain a pending partial word first, up to four bytes
        for (int b = 0; b < 4; b++) begin
          if (bits_left_next != 6'd0 && 3'(b) < nbytes) begin
            sh = 6'd32 - bits_left_next;
            bi = {24'h0, word[8*b +: 8]};
            bo = (bi ^ (ks_next >> sh)) & 32'hff;
            pmac_next = pmac_next ^ ((cmd.enc ? bi : bo) << sh);
            bits_left_next = bits_left_next - 6'd8;
            res = res | (bo << (8 * b));
            pos = 3'(b + 1);
          end
        end
        if (bits_left != 6'd0 && bits_left_next == 6'd0) begin
          do_absorb(r_next, crc_next, pmac_next);
          pmac_next = 32'h0;
        end
        if (bits_left == 6'd0 || bits_left_next == 6'd0) begin
          if (pos == 3'd0 && nbytes == 3'd4) begin
            do_step(r_next, konst, kso);
            ks_next = kso;
            res = word ^ kso;
            do_absorb(r_next, crc_next, cmd.enc ? word : res);
          end else if (pos < nbytes) begin
            do_step(r_next, konst, kso);
            ks_next = kso;
            pmac_next = 32'h0;
            bits_left_next = 6'd32;
            for (int b = 0; b < 4; b++) begin
              if (3'(b) >= pos && 3'(b) < nbytes) begin
                sh = 6'd32 - bits_left_next;
                bi = {24'h0, word[8*b +: 8]};
                bo = (bi ^ (ks_next >> sh)) & 32'hff;
                pmac_next = pmac_next ^ ((cmd.enc ? bi : bo) << sh);
                bits_left_next = bits_left_next - 6'd8;
                res = res | (bo << (8 * b));
              end
            end
          end
        end
      end
      default: ;
    endcase
    res_word = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Fibonacci preset
      for (int i = 0; i < scm_pkg::RegN; i++) r[i] <= fib_rst(i);
      for (int i = 0; i < scm_pkg::RegN; i++) crc[i] <= 32'h0;
      konst <= scm_pkg::InitConst;
      ks <= 32'h0;
      pmac <= 32'h0;
      bits_left <= 6'd0;
      load_len <= 32'h0;
    end else begin
      for (int i = 0; i < scm_pkg::RegN; i++) begin
        r[i] <= r_next[i];
        crc[i] <= crc_next[i];
      end
      konst <= konst_next;
      ks <= ks_next;
      pmac <= pmac_next;
      bits_left <= bits_left_next;
      load_len <= load_len_next;
    end
    if (!rst && cmd.op == scm_pkg::OP_LOADEND && cmd.save)
      for (int i = 0; i < scm_pkg::RegN; i++) saved[i] <= r_next[i];
  end

endmodule

[rtl/scm_ctrl.sv]
// Command sequencer: accepts items, issues datapath ops, emits results.
`timescale 1ns / 1ps
module scm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] in_cmd,
  input  logic [31:0] in_word,
  input  logic [2:0] in_bytes,
  input  logic in_last,
  output scm_pkg::scm_cmd_t cmd,
  output logic [31:0] dp_word,
  output logic [2:0] dp_bytes,
  input  logic [31:0] dp_res,
  input  logic [31:0] dp_ks,
  input  logic out_ready,
  output logic out_valid,
  output logic [31:0] out_word,
  output logic [2:0] out_bytes,
  output logic out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN = 3'd1;
  localparam logic [2:0] S_SPREAD = 3'd2;
  localparam logic [2:0] S_LEND = 3'd3;
  localparam logic [2:0] S_FIN1 = 3'd4;
  localparam logic [2:0] S_MAC = 3'd5;
  localparam logic [2:0] S_MACOUT = 3'd6;
  localparam logic [2:0] S_WAIT = 3'd7;

  logic [2:0] state;
  logic [6:0] mac_bytes, remain;
  logic [3:0] cnt;
  logic loading, save, spread_fin;
  logic [2:0] c_cmd;
  logic [31:0] c_word;
  logic [2:0] c_bytes;
  logic c_last;
  logic [2:0] nb;
  logic [2:0] take;

  assign nb = (c_bytes > 3'd4) ? 3'd4 : c_bytes;
  assign take = (remain >= 7'd4) ? 3'd4 : remain[2:0];
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign dp_word = c_word;
  assign dp_bytes = nb;

  always_comb begin
    cmd = '{op: scm_pkg::OP_NONE, save: save, enc: (c_cmd == scm_pkg::CMD_ENC)};
    unique case (state)
      S_LEN: cmd.op = scm_pkg::OP_LOADLEN;
      S_SPREAD: cmd.op = scm_pkg::OP_SPREAD;
      S_LEND: cmd.op = scm_pkg::OP_LOADEND;
      S_FIN1: cmd.op = scm_pkg::OP_FIN1;
      // no step when the MAC is empty
      S_MAC: cmd.op = (remain == 7'd0) ? scm_pkg::OP_NONE : scm_pkg::OP_MACW;
      default: cmd.op = scm_pkg::OP_NONE;
    endcase
    if (state == S_WAIT) begin
      unique case (c_cmd) inside
        scm_pkg::CMD_KEY, scm_pkg::CMD_NONCE:
          cmd.op = loading ? scm_pkg::OP_LOADW
                 : (c_cmd == scm_pkg::CMD_KEY ? scm_pkg::OP_FIB : scm_pkg::OP_RESTORE);
        scm_pkg::CMD_ENC, scm_pkg::CMD_DEC: cmd.op = scm_pkg::OP_CRYPT;
        scm_pkg::CMD_FINISH: cmd.op = scm_pkg::OP_FIN0;
        default: cmd.op = scm_pkg::OP_NONE;
      endcase
      if (cmd.op == scm_pkg::OP_LOADW && nb == 3'd0) cmd.op = scm_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mac_bytes <= 7'd4;
      loading <= 1'b0;
      out_valid <= 1'b0;
      save <= 1'b0;
      cnt <= 4'd0;
      spread_fin <= 1'b0;
    end else begin
      if (cfg_we) mac_bytes <= cfg_data;
      // S_MACOUT handles its own handshake
      if (out_valid && out_ready && state != S_MACOUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            c_cmd <= in_cmd;
            c_word <= in_word;
            c_bytes <= in_bytes;
            c_last <= in_last;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (c_cmd == scm_pkg::CMD_KEY || c_cmd == scm_pkg::CMD_NONCE) begin
            if (!loading) begin
              loading <= 1'b1;  // preset done, now the word itself
            end else begin
              save <= (c_cmd == scm_pkg::CMD_KEY);
              if (c_last) begin
                state <= S_LEN;
              end else begin
                state <= S_IDLE;
                out_valid <= 1'b1;
                out_word <= 32'h0;
                out_bytes <= 3'd0;
                out_last <= 1'b1;
              end
            end
          end else if (c_cmd == scm_pkg::CMD_ENC || c_cmd == scm_pkg::CMD_DEC) begin
            loading <= 1'b0;
            out_valid <= 1'b1;
            out_word <= dp_res;
            out_bytes <= nb;
            out_last <= 1'b1;
            state <= S_IDLE;
          end else if (c_cmd == scm_pkg::CMD_FINISH) begin
            loading <= 1'b0;
            remain <= (mac_bytes > 7'(scm_pkg::MacMaxBytes))
                    ? 7'(scm_pkg::MacMaxBytes) : mac_bytes;
            state <= S_FIN1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LEN: begin
          cnt <= 4'd0;
          spread_fin <= 1'b0;
          state <= S_SPREAD;
        end
        S_SPREAD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= spread_fin ? S_MAC : S_LEND;
        end
        S_LEND: begin
          loading <= 1'b0;
          out_valid <= 1'b1;
          out_word <= 32'h0;
          out_bytes <= 3'd0;
          out_last <= 1'b1;
          state <= S_IDLE;
        end
        S_FIN1: begin
          cnt <= 4'd0;
          spread_fin <= 1'b1;
          state <= S_SPREAD;
        end
        S_MAC: begin
          if (remain == 7'd0) begin
            out_valid <= 1'b1;
            out_word <= 32'h0;
            out_bytes <= 3'd0;
            out_last <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MACOUT;
          end
        end
        S_MACOUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word <= dp_ks & scm_pkg::byte_mask(take);
            out_bytes <= take;
            out_last <= (remain == 7'(take));
            remain <= remain - 7'(take);
            state <= (remain == 7'(take)) ? S_IDLE : S_MAC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/shannon_stream_cipher_mac_core.sv]
// Top level of the stream cipher MAC core.
//
// Input channel s_axis: tdata holds data_word (bits 31:0) and byte_count
// (34:32), padded to 40 bits; tuser holds cmd; tlast holds last_word. An item
// is taken when s_axis_tvalid and s_axis_tready are both high.
// Output channel m_axis: tdata holds out_word (31:0) and out_bytes (34:32);
// tlast marks the final result of an input item.
// cfg_we/cfg_data write mac_bytes; write only while the block is idle.
// One item at a time: an encrypt or decrypt item is worked on in the cycle
// after it is taken and its result is valid from the next edge; the next item
// is taken only once the result has been accepted. The first word of a load
// first presets the register; the last load word then adds a length mix, 16
// diffusion steps and a fold. A finish absorbs any partial word and folds in
// the tag, then runs 16 diffusion steps before its MAC words, each of which
// takes a register step. The diffusion runs one register step at a time.
// Reset clears the register to its Fibonacci preset, the CRC register to zero
// and mac_bytes to 4. When the receiver stalls, the result holds and no new
// item is taken.
`timescale 1ns / 1ps
module shannon_stream_cipher_mac_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_word, byte_count
  input  logic [2:0] s_axis_tuser,   // cmd
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_word, out_bytes
  output logic m_axis_tlast
);

  scm_pkg::scm_cmd_t cmd;
  logic [31:0] dp_word, dp_res, dp_ks, ow;
  logic [2:0] dp_bytes, ob;

  scm_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser), .in_word(s_axis_tdata[31:0]),
    .in_bytes(s_axis_tdata[34:32]), .in_last(s_axis_tlast),
    .cmd, .dp_word, .dp_bytes, .dp_res, .dp_ks,
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
    .out_word(ow), .out_bytes(ob), .out_last(m_axis_tlast)
  );

  scm_datapath u_dp (
    .clk, .rst, .cmd, .word(dp_word), .nbytes(dp_bytes),
    .res_word(dp_res), .ks_out(dp_ks)
  );

  assign m_axis_tdata = {5'h0, ob, ow};

endmodule
